FILE: src/tip_pkg.sv
// ----------------------------------------------------------------------------
// tip_pkg: shared constants and types
// Widths, sizes and the row tag used by the 2x2 to 4x4 interpolator.
// ----------------------------------------------------------------------------
package tip_pkg;

  // Element geometry
  localparam int unsigned Dofs1D  = 2;
  localparam int unsigned Quads1D = 4;
  localparam int unsigned NumRegs = Quads1D * Dofs1D;

  // Field widths
  localparam int unsigned DataW   = 32;  // Q16.16 nodal and quadrature values
  localparam int unsigned CoefW   = 18;  // Q2.16 basis values
  localparam int unsigned PartW   = 52;  // exact x-pass partial sum, Q.32
  localparam int unsigned RowW    = 2;
  localparam int unsigned CfgIdxW = 4;   // wide enough to see out-of-range writes
  localparam int unsigned CoefIdxW = $clog2(NumRegs);

  localparam logic [RowW-1:0] LastRow = RowW'(Quads1D - 1);

  // Tag that travels with one quadrature row down the y pass
  typedef struct packed {
    logic [RowW-1:0] row;
    logic            last;
    logic            done;
  } tip_tag_t;

endpackage

FILE: src/tip_ifs.sv
// ----------------------------------------------------------------------------
// tip interfaces: element input, row output and configuration channels
// Valid/ready channels; a transfer happens when valid and ready are high.
// ----------------------------------------------------------------------------
interface tip_in_if import tip_pkg::*; ();
  logic                    valid;
  logic                    ready;
  logic signed [DataW-1:0] dof_x0_y0;
  logic signed [DataW-1:0] dof_x1_y0;
  logic signed [DataW-1:0] dof_x0_y1;
  logic signed [DataW-1:0] dof_x1_y1;
  logic                    final_element;

  modport source (output valid, dof_x0_y0, dof_x1_y0, dof_x0_y1, dof_x1_y1,
                  final_element, input ready);
  modport sink   (input valid, dof_x0_y0, dof_x1_y0, dof_x0_y1, dof_x1_y1,
                  final_element, output ready);
endinterface

interface tip_out_if import tip_pkg::*; ();
  logic                    valid;
  logic                    ready;
  logic [RowW-1:0]         row_index;
  logic signed [DataW-1:0] quad_x0;
  logic signed [DataW-1:0] quad_x1;
  logic signed [DataW-1:0] quad_x2;
  logic signed [DataW-1:0] quad_x3;
  logic                    last_row;
  logic                    batch_done;

  modport source (output valid, row_index, quad_x0, quad_x1, quad_x2, quad_x3,
                  last_row, batch_done, input ready);
  modport sink   (input valid, row_index, quad_x0, quad_x1, quad_x2, quad_x3,
                  last_row, batch_done, output ready);
endinterface

interface tip_cfg_if import tip_pkg::*; ();
  logic                    valid;
  logic                    ready;
  logic [CfgIdxW-1:0]      reg_idx;
  logic [CoefW-1:0]        wdata;

  modport source (output valid, reg_idx, wdata, input ready);
  modport sink   (input valid, reg_idx, wdata, output ready);
endinterface

FILE: src/tensor_interp_2x2_to_4x4.sv
// ----------------------------------------------------------------------------
// tensor_interp_2x2_to_4x4: 2x2 to 4x4 tensor-product interpolation
// Sum-factorized x pass in eight lanes, y pass in four lanes, one row out.
// ----------------------------------------------------------------------------
// Each accepted element yields four result rows, qy = 0..3, one per cycle
// while the receiver does not stall; the four y-pass lanes, which share the
// held x-pass partials and produce one row a cycle, set that rate. The next
// element is taken while the current one is still being emitted, so
// back-to-back elements keep the output busy every cycle unless the
// receiver stalls. Input data reaches the output through the x-product,
// x-partial, y-product and output registers in turn. The basis matrix is
// written through the configuration channel (index q*2+d for B[q][d]; other
// indexes are ignored) and must only change while the block is idle.
module tensor_interp_2x2_to_4x4 import tip_pkg::*; (
  input  logic       clk_i,
  input  logic       rst_ni,
  tip_cfg_if.sink    cfg_i,
  tip_in_if.sink     in_i,
  tip_out_if.source  out_o
);

  // Basis coefficients
  logic signed [CoefW-1:0] b_q [NumRegs];

  assign cfg_i.ready = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < NumRegs; i++) begin
        b_q[i] <= '0;
      end
    end else if (cfg_i.valid && (cfg_i.reg_idx < CfgIdxW'(NumRegs))) begin
      b_q[cfg_i.reg_idx[CoefIdxW-1:0]] <= $signed(cfg_i.wdata);
    end
  end

  // Pipeline control
  logic            s1_v_q, s1_v_d, fin1_q;
  logic            s2_v_q, s2_v_d, fin2_q;
  logic [RowW-1:0] row_q, row_d;
  logic            s3_v_q, s3_v_d;
  tip_tag_t        tag3_q;
  logic            m_ready;
  logic            accept, s1_go, s2_free, issue, s3_free;

  assign s3_free = !s3_v_q || m_ready;
  assign issue   = s2_v_q && s3_free;
  assign s2_free = !s2_v_q || (issue && (row_q == LastRow));
  assign s1_go   = s1_v_q && s2_free;
  assign in_i.ready = !s1_v_q || s2_free;
  assign accept  = in_i.valid && in_i.ready;

  always_comb begin
    s1_v_d = s1_v_q;
    if (accept) begin
      s1_v_d = 1'b1;
    end else if (s1_go) begin
      s1_v_d = 1'b0;
    end

    s2_v_d = s2_v_q;
    row_d  = row_q;
    if (issue) begin
      row_d = row_q + 1'b1;
    end
    if (s1_go) begin
      s2_v_d = 1'b1;
      row_d  = '0;
    end else if (s2_free) begin
      s2_v_d = 1'b0;
    end

    s3_v_d = s3_v_q;
    if (issue) begin
      s3_v_d = 1'b1;
    end else if (m_ready) begin
      s3_v_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_v_q <= 1'b0;
      s2_v_q <= 1'b0;
      row_q  <= '0;
      s3_v_q <= 1'b0;
    end else begin
      s1_v_q <= s1_v_d;
      s2_v_q <= s2_v_d;
      row_q  <= row_d;
      s3_v_q <= s3_v_d;
    end
  end

  // Side-band flags travelling with the data
  always_ff @(posedge clk_i) begin
    if (accept) begin
      fin1_q <= in_i.final_element;
    end
    if (s1_go) begin
      fin2_q <= fin1_q;
    end
    if (issue) begin
      tag3_q.row  <= row_q;
      tag3_q.last <= (row_q == LastRow);
      tag3_q.done <= (row_q == LastRow) && fin2_q;
    end
  end

  // Nodal values g[dx][dy]
  logic signed [DataW-1:0] g [Dofs1D][Dofs1D];

  assign g[0][0] = in_i.dof_x0_y0;
  assign g[1][0] = in_i.dof_x1_y0;
  assign g[0][1] = in_i.dof_x0_y1;
  assign g[1][1] = in_i.dof_x1_y1;

  // X pass: one lane per t[dy][qx]
  logic signed [PartW-1:0] t [Dofs1D][Quads1D];

  for (genvar dy = 0; dy < Dofs1D; dy++) begin : g_xdy
    for (genvar qx = 0; qx < Quads1D; qx++) begin : g_xqx
      tip_x_lane u_x_lane (
        .clk_i    (clk_i),
        .mul_en_i (accept),
        .sum_en_i (s1_go),
        .b0_i     (b_q[qx*Dofs1D]),
        .b1_i     (b_q[qx*Dofs1D + 1]),
        .g0_i     (g[0][dy]),
        .g1_i     (g[1][dy]),
        .t_o      (t[dy][qx])
      );
    end
  end

  // Y pass: basis values of the row being issued, one lane per column
  logic signed [CoefW-1:0] by0, by1;
  logic signed [DataW-1:0] quad [Quads1D];

  assign by0 = b_q[{row_q, 1'b0}];
  assign by1 = b_q[{row_q, 1'b1}];

  for (genvar qx = 0; qx < Quads1D; qx++) begin : g_y
    tip_y_lane u_y_lane (
      .clk_i    (clk_i),
      .mul_en_i (issue),
      .b0_i     (by0),
      .b1_i     (by1),
      .t0_i     (t[0][qx]),
      .t1_i     (t[1][qx]),
      .quad_o   (quad[qx])
    );
  end

  // Merge the lane values into the output row
  tip_merge u_merge (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .valid_i (s3_v_q),
    .ready_o (m_ready),
    .tag_i   (tag3_q),
    .quad_i  (quad),
    .out_o   (out_o)
  );

  // Assertions
  a_row_restart: assert property (@(posedge clk_i) disable iff (!rst_ni)
    s1_go |=> (s2_v_q && (row_q == '0)))
    else $error("row counter not restarted on element load");

  a_elem_drain: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (issue && (row_q == LastRow) && !s1_go) |=> !s2_v_q)
    else $error("element still held after its last row");

  a_done_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    s3_v_q |-> (!tag3_q.done || (tag3_q.last && (tag3_q.row == LastRow))))
    else $error("batch end flagged off the last row");

  a_stall_cause: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !in_i.ready |-> (s1_v_q && s2_v_q))
    else $error("input stalled with free stages");

  a_issue_fill: assert property (@(posedge clk_i) disable iff (!rst_ni)
    issue |=> s3_v_q)
    else $error("issued row lost before the output stage");

endmodule

FILE: src/tip_x_lane.sv
// ----------------------------------------------------------------------------
// tip_x_lane: one x-pass lane
// Forms t[dy][qx] = B[qx][0]*g[0][dy] + B[qx][1]*g[1][dy] exactly, with the
// two products registered before the sum.
// ----------------------------------------------------------------------------
module tip_x_lane import tip_pkg::*; (
  input  logic                    clk_i,
  input  logic                    mul_en_i,
  input  logic                    sum_en_i,
  input  logic signed [CoefW-1:0] b0_i,
  input  logic signed [CoefW-1:0] b1_i,
  input  logic signed [DataW-1:0] g0_i,
  input  logic signed [DataW-1:0] g1_i,
  output logic signed [PartW-1:0] t_o
);

  localparam int unsigned ProdW = CoefW + DataW;

  logic signed [ProdW-1:0] p0_q, p1_q;
  logic signed [PartW-1:0] t_q, t_d;

  // Products, one per dof
  always_ff @(posedge clk_i) begin
    if (mul_en_i) begin
      p0_q <= b0_i * g0_i;
      p1_q <= b1_i * g1_i;
    end
  end

  // Exact partial sum, held for the whole y pass of the element
  assign t_d = PartW'(p0_q) + PartW'(p1_q);

  always_ff @(posedge clk_i) begin
    if (sum_en_i) begin
      t_q <= t_d;
    end
  end

  assign t_o = t_q;

endmodule

FILE: src/tip_y_lane.sv
// ----------------------------------------------------------------------------
// tip_y_lane: one y-pass lane (one quadrature column qx)
// Multiplies the row's two basis values by the split partials, registers the
// products, then rounds to Q16.16 (ties up) and saturates.
// ----------------------------------------------------------------------------
module tip_y_lane import tip_pkg::*; (
  input  logic                    clk_i,
  input  logic                    mul_en_i,
  input  logic signed [CoefW-1:0] b0_i,
  input  logic signed [CoefW-1:0] b1_i,
  input  logic signed [PartW-1:0] t0_i,
  input  logic signed [PartW-1:0] t1_i,
  output logic signed [DataW-1:0] quad_o
);

  localparam int unsigned HiW  = PartW - 16;       // t >>> 16
  localparam int unsigned LoW  = 17;               // t[15:0], zero extended
  localparam int unsigned HiPW = CoefW + HiW;
  localparam int unsigned LoPW = CoefW + LoW;
  localparam int unsigned AccW = 72;
  localparam int unsigned RndW = AccW - 32;

  localparam logic signed [AccW-1:0] RoundHalf = 72'sh0000_0000_0080_0000_00;
  localparam logic signed [RndW-1:0] QMax      = 40'sh00_7FFF_FFFF;
  localparam logic signed [RndW-1:0] QMin      = 40'shFF_8000_0000;

  logic signed [HiW-1:0]  th0, th1;
  logic signed [LoW-1:0]  tl0, tl1;
  logic signed [HiPW-1:0] hi0_q, hi1_q;
  logic signed [LoPW-1:0] lo0_q, lo1_q;
  logic signed [AccW-1:0] acc;
  logic signed [RndW-1:0] rnd;

  // Split each partial into a high part and a non-negative low part
  assign th0 = t0_i[PartW-1:16];
  assign th1 = t1_i[PartW-1:16];
  assign tl0 = $signed({1'b0, t0_i[15:0]});
  assign tl1 = $signed({1'b0, t1_i[15:0]});

  always_ff @(posedge clk_i) begin
    if (mul_en_i) begin
      hi0_q <= b0_i * th0;
      hi1_q <= b1_i * th1;
      lo0_q <= b0_i * tl0;
      lo1_q <= b1_i * tl1;
    end
  end

  // Recombine exactly, add half an LSB, drop 32 fraction bits
  always_comb begin
    acc = ((AccW'(hi0_q) + AccW'(hi1_q)) <<< 16) + AccW'(lo0_q) + AccW'(lo1_q)
          + RoundHalf;
    rnd = acc[AccW-1:32];
    if (rnd > QMax) begin
      quad_o = QMax[DataW-1:0];
    end else if (rnd < QMin) begin
      quad_o = QMin[DataW-1:0];
    end else begin
      quad_o = rnd[DataW-1:0];
    end
  end

endmodule

FILE: src/tip_merge.sv
// ----------------------------------------------------------------------------
// tip_merge: output row register
// Collects the four lane values and the row tag into one result row and
// holds it until the downstream transfer.
// ----------------------------------------------------------------------------
module tip_merge import tip_pkg::*; (
  input  logic                    clk_i,
  input  logic                    rst_ni,
  input  logic                    valid_i,
  output logic                    ready_o,
  input  tip_tag_t                tag_i,
  input  logic signed [DataW-1:0] quad_i [Quads1D],
  tip_out_if.source               out_o
);

  logic                    valid_q, valid_d;
  logic                    load;
  tip_tag_t                tag_q;
  logic signed [DataW-1:0] quad_q [Quads1D];

  assign ready_o = !valid_q || out_o.ready;
  assign load    = valid_i && ready_o;

  // Output valid
  always_comb begin
    valid_d = valid_q;
    if (load) begin
      valid_d = 1'b1;
    end else if (out_o.ready) begin
      valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  // Row payload
  always_ff @(posedge clk_i) begin
    if (load) begin
      tag_q  <= tag_i;
      quad_q <= quad_i;
    end
  end

  assign out_o.valid      = valid_q;
  assign out_o.row_index  = tag_q.row;
  assign out_o.last_row   = tag_q.last;
  assign out_o.batch_done = tag_q.done;
  assign out_o.quad_x0    = quad_q[0];
  assign out_o.quad_x1    = quad_q[1];
  assign out_o.quad_x2    = quad_q[2];
  assign out_o.quad_x3    = quad_q[3];

endmodule

FILE: verif/tip_row_checker.sv
// ----------------------------------------------------------------------------
// tip_row_checker: row predictor and scoreboard for the 2x2 to 4x4 interpolator
// Watches the configuration, element and row channels, keeps its own copy of
// the basis matrix, works out the four rows of each accepted element in exact
// wide arithmetic and compares every row transfer against the oldest one due.
// ----------------------------------------------------------------------------
module tip_row_checker import tip_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  tip_cfg_if          cfg_i,
  tip_in_if           in_i,
  tip_out_if          out_i,
  output int unsigned errors_o,
  output int unsigned pending_o,
  output int unsigned rows_o,
  output int unsigned clamps_o
);

  // Wide enough for the exact y-pass sum (18 + 52 bits plus carries)
  localparam int unsigned WideW = 80;
  localparam logic signed [WideW-1:0] HalfLsb = WideW'(64'h8000_0000);
  localparam logic signed [WideW-1:0] SatHi   = WideW'(64'h7FFF_FFFF);
  localparam logic signed [WideW-1:0] SatLo   = -HalfLsb;

  typedef struct packed {
    tip_tag_t                      tag;
    logic [Quads1D-1:0][DataW-1:0] quad;
  } quad_row_t;

  quad_row_t               rows_due [$];
  logic signed [CoefW-1:0] basis [Quads1D][Dofs1D];

  int unsigned err_count   = 0;
  int unsigned due_count   = 0;
  int unsigned row_count   = 0;
  int unsigned clamp_count = 0;

  assign errors_o  = err_count;
  assign pending_o = due_count;
  assign rows_o    = row_count;
  assign clamps_o  = clamp_count;

  task automatic report_mismatch(input string what, input longint got, input longint want);
    err_count++;
    $display("tip_row_checker: row %0d: %s is %0d, expected %0d", row_count, what, got, want);
  endtask

  // Sum-factorized interpolation of one element; queues its four rows
  function automatic void interp_element(input logic signed [DataW-1:0] g00, g10, g01, g11,
                                         input logic fin);
    logic signed [WideW-1:0] nodal [Dofs1D][Dofs1D];  // [dx][dy]
    logic signed [WideW-1:0] part [Dofs1D][Quads1D];  // [dy][qx]
    logic signed [WideW-1:0] coef;
    logic signed [WideW-1:0] acc;
    quad_row_t               r;
    nodal[0][0] = g00;
    nodal[1][0] = g10;
    nodal[0][1] = g01;
    nodal[1][1] = g11;
    // x pass, kept exact
    for (int dy = 0; dy < Dofs1D; dy++) begin
      for (int qx = 0; qx < Quads1D; qx++) begin
        acc = '0;
        for (int dx = 0; dx < Dofs1D; dx++) begin
          coef = basis[qx][dx];
          acc += coef * nodal[dx][dy];
        end
        part[dy][qx] = acc;
      end
    end
    // y pass, one rounding (ties up) and a clamp per value
    for (int qy = 0; qy < Quads1D; qy++) begin
      r.tag.row  = RowW'(qy);
      r.tag.last = (qy == Quads1D - 1);
      r.tag.done = r.tag.last && fin;
      for (int qx = 0; qx < Quads1D; qx++) begin
        acc = HalfLsb;
        for (int dy = 0; dy < Dofs1D; dy++) begin
          coef = basis[qy][dy];
          acc += coef * part[dy][qx];
        end
        acc = acc >>> 32;
        if (acc > SatHi) begin
          r.quad[qx] = SatHi[DataW-1:0];
          clamp_count++;
        end else if (acc < SatLo) begin
          r.quad[qx] = SatLo[DataW-1:0];
          clamp_count++;
        end else begin
          r.quad[qx] = acc[DataW-1:0];
        end
      end
      rows_due.push_back(r);
    end
  endfunction

  // Transfers are taken at the rising edge; rows are checked before new
  // elements are queued so a row can never match its own element's input
  always @(posedge clk_i or negedge rst_ni) begin : watch
    quad_row_t                     want;
    logic [Quads1D-1:0][DataW-1:0] got_quad;
    if (!rst_ni) begin
      rows_due.delete();
      due_count = 0;
      for (int q = 0; q < Quads1D; q++) begin
        for (int d = 0; d < Dofs1D; d++) basis[q][d] = '0;
      end
    end else begin
      if (cfg_i.valid && cfg_i.ready && cfg_i.reg_idx < NumRegs) begin
        basis[cfg_i.reg_idx / Dofs1D][cfg_i.reg_idx % Dofs1D] = cfg_i.wdata;
      end

      if (out_i.valid && out_i.ready) begin
        row_count++;
        if (rows_due.size() == 0) begin
          report_mismatch("unexpected row, row_index", out_i.row_index, -1);
        end else begin
          want     = rows_due.pop_front();
          got_quad = {out_i.quad_x3, out_i.quad_x2, out_i.quad_x1, out_i.quad_x0};
          if (out_i.row_index !== want.tag.row)
            report_mismatch("row_index", out_i.row_index, want.tag.row);
          for (int qx = 0; qx < Quads1D; qx++) begin
            if (got_quad[qx] !== want.quad[qx])
              report_mismatch($sformatf("quad_x%0d", qx), $signed(got_quad[qx]),
                              $signed(want.quad[qx]));
          end
          if (out_i.last_row !== want.tag.last)
            report_mismatch("last_row", out_i.last_row, want.tag.last);
          if (out_i.batch_done !== want.tag.done)
            report_mismatch("batch_done", out_i.batch_done, want.tag.done);
        end
      end

      if (in_i.valid && in_i.ready) begin
        interp_element(in_i.dof_x0_y0, in_i.dof_x1_y0, in_i.dof_x0_y1, in_i.dof_x1_y1,
                       in_i.final_element);
      end

      due_count = rows_due.size();
    end
  end

endmodule

FILE: verif/tb_tensor_interp_2x2_to_4x4.sv
// ----------------------------------------------------------------------------
// tb_tensor_interp_2x2_to_4x4: stimulus and verdict for the interpolator
// Uses the reset (zero) basis, then loads half, extreme, linear and random
// basis matrices, sends directed and random elements under varying sender
// and receiver stalls, and leaves all row checking to tip_row_checker.
// ----------------------------------------------------------------------------
module tb_tensor_interp_2x2_to_4x4 import tip_pkg::*; ();

  localparam int unsigned QuietLimit = 3000;  // cycles without any transfer
  localparam int unsigned HoldCycles = 400;   // long receiver hold-off

  localparam logic [CoefW-1:0] CoefZero      = 18'h00000;
  localparam logic [CoefW-1:0] CoefOne       = 18'h10000;
  localparam logic [CoefW-1:0] CoefHalf      = 18'h08000;
  localparam logic [CoefW-1:0] CoefThird     = 18'd21845;
  localparam logic [CoefW-1:0] CoefTwoThirds = 18'd43691;
  localparam logic [CoefW-1:0] CoefMax       = 18'h1FFFF;
  localparam logic [CoefW-1:0] CoefMin       = 18'h20000;

  logic clk   = 1'b0;
  logic rst_n = 1'b0;

  tip_cfg_if cfg_ch ();
  tip_in_if  elem_ch ();
  tip_out_if row_ch ();

  int unsigned errors, pending, rows_checked, clamps;
  int unsigned elements_sent = 0;
  int unsigned cfg_writes    = 0;
  int unsigned basis_sets    = 0;
  int unsigned send_idle_pct = 0;
  int unsigned recv_idle_pct = 0;
  int unsigned hold_len      = 0;
  int unsigned hold_asks     = 0;
  int unsigned quiet_cycles  = 0;

  tensor_interp_2x2_to_4x4 dut (
    .clk_i  (clk),
    .rst_ni (rst_n),
    .cfg_i  (cfg_ch),
    .in_i   (elem_ch),
    .out_o  (row_ch)
  );

  tip_row_checker u_checker (
    .clk_i     (clk),
    .rst_ni    (rst_n),
    .cfg_i     (cfg_ch),
    .in_i      (elem_ch),
    .out_i     (row_ch),
    .errors_o  (errors),
    .pending_o (pending),
    .rows_o    (rows_checked),
    .clamps_o  (clamps)
  );

  // Clock
  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  // Watchdog: ends the run when no channel has moved for too long
  wire moved = (cfg_ch.valid && cfg_ch.ready) || (elem_ch.valid && elem_ch.ready) ||
               (row_ch.valid && row_ch.ready);

  always @(posedge clk) begin
    if (!rst_n || moved) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= QuietLimit) begin
      $display("tb_tensor_interp_2x2_to_4x4: done, errors");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  // Row receiver: random stalls plus an occasional long hold-off
  initial begin : row_sink
    int unsigned hold_left;
    int unsigned hold_seen;
    logic        take;
    hold_left    = 0;
    hold_seen    = 0;
    row_ch.ready = 1'b0;
    forever begin
      @(posedge clk);
      if (hold_asks != hold_seen) begin
        hold_seen = hold_asks;
        hold_left = hold_len;
      end
      take = (hold_left == 0) && ($urandom_range(99) >= recv_idle_pct);
      if (hold_left != 0) hold_left--;
      @(negedge clk);
      row_ch.ready = take;
    end
  end

  // Stimulus helpers; all are entered and left at a falling edge
  task automatic write_reg(input logic [CfgIdxW-1:0] idx, input logic [CoefW-1:0] data);
    cfg_ch.valid   = 1'b1;
    cfg_ch.reg_idx = idx;
    cfg_ch.wdata   = data;
    do @(posedge clk); while (!cfg_ch.ready);
    @(negedge clk);
    cfg_ch.valid = 1'b0;
    cfg_writes++;
  endtask

  task automatic write_basis(input logic [CoefW-1:0] vals [NumRegs]);
    for (int i = 0; i < NumRegs; i++) write_reg(CfgIdxW'(i), vals[i]);
    basis_sets++;
  endtask

  task automatic send_element(input logic [DataW-1:0] d00, d10, d01, d11,
                              input logic fin);
    while ($urandom_range(99) < send_idle_pct) begin
      elem_ch.valid = 1'b0;
      @(negedge clk);
    end
    elem_ch.valid         = 1'b1;
    elem_ch.dof_x0_y0     = d00;
    elem_ch.dof_x1_y0     = d10;
    elem_ch.dof_x0_y1     = d01;
    elem_ch.dof_x1_y1     = d11;
    elem_ch.final_element = fin;
    do @(posedge clk); while (!elem_ch.ready);
    @(negedge clk);
    elem_ch.valid = 1'b0;
    elements_sent++;
  endtask

  // Sender holds off until every queued row has been seen
  task automatic wait_drained();
    while (pending != 0) @(negedge clk);
  endtask

  function automatic logic [DataW-1:0] rand_dof();
    case ($urandom_range(9))
      0, 1, 2, 3: return $urandom;
      4, 5, 6, 7: return DataW'($urandom_range(32'hF_FFFF)) - 32'h8_0000;
      8:          return {($urandom_range(1) != 0) ? 2'b01 : 2'b10, 30'($urandom)};
      default:    return ($urandom_range(1) != 0) ? 32'h7FFF_FFFF : 32'h8000_0000;
    endcase
  endfunction

  function automatic logic [CoefW-1:0] rand_coef();
    case ($urandom_range(5))
      0, 1, 2: return CoefW'($urandom);
      3, 4:    return CoefW'($urandom_range(32'h2_0000) - 32'h1_0000);  // within +-1.0
      default: return ($urandom_range(1) != 0) ? CoefMax : CoefMin;
    endcase
  endfunction

  // One random basis followed by a run of random elements
  task automatic run_random_phase(input int unsigned s_pct, r_pct, n_items,
                                  input bit squeeze);
    logic [CoefW-1:0] coefs [NumRegs];
    wait_drained();
    for (int i = 0; i < NumRegs; i++) coefs[i] = rand_coef();
    write_basis(coefs);
    if ($urandom_range(1) != 0)
      write_reg(CfgIdxW'($urandom_range(15, NumRegs)), CoefW'($urandom));
    send_idle_pct = s_pct;
    recv_idle_pct = r_pct;
    for (int k = 0; k < n_items; k++) begin
      if (squeeze && k == n_items / 3) begin
        hold_len = HoldCycles;
        hold_asks++;
      end
      if (squeeze && k == 2 * n_items / 3) wait_drained();
      send_element(rand_dof(), rand_dof(), rand_dof(), rand_dof(), $urandom_range(7) == 0);
    end
  endtask

  initial begin : stimulus
    elem_ch.valid         = 1'b0;
    elem_ch.dof_x0_y0     = '0;
    elem_ch.dof_x1_y0     = '0;
    elem_ch.dof_x0_y1     = '0;
    elem_ch.dof_x1_y1     = '0;
    elem_ch.final_element = 1'b0;
    cfg_ch.valid          = 1'b0;
    cfg_ch.reg_idx        = '0;
    cfg_ch.wdata          = '0;
    repeat (11) @(negedge clk);
    rst_n = 1'b1;
    @(negedge clk);

    // Basis still at reset: all rows are zero, batch end still flagged
    send_element(32'h7FFF_FFFF, 32'h8000_0000, 32'hFFFF_FFFF, 32'h0000_0001, 1'b1);
    send_element(32'h8000_0000, 32'h7FFF_FFFF, 32'h0000_0000, 32'h8000_0000, 1'b0);

    // Half weight on dof 0 only: exact half-LSB ties round toward plus infinity;
    // writes past the last register must leave the basis alone
    wait_drained();
    write_basis('{CoefHalf, CoefZero, CoefHalf, CoefZero,
                  CoefHalf, CoefZero, CoefHalf, CoefZero});
    write_reg(CfgIdxW'(NumRegs), CoefMax);
    write_reg(CfgIdxW'(15), CoefMin);
    send_element(32'sd2, 32'sd5, -32'sd7, 32'sd9, 1'b0);
    send_element(-32'sd2, 32'sd3, 32'sd11, -32'sd1, 1'b0);
    send_element(32'sd6, 32'h7FFF_FFFF, 32'sd0, 32'sd0, 1'b0);
    send_element(-32'sd6, 32'h8000_0000, 32'sd6, 32'sd6, 1'b1);
    send_element(32'h7FFF_FFFF, 32'sd0, 32'h8000_0000, 32'sd0, 1'b0);

    // Extreme coefficients: clamps at both rails
    wait_drained();
    write_basis('{CoefMax, CoefMax, CoefMin, CoefMin,
                  CoefMax, CoefMin, CoefMin, CoefMax});
    send_element(32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 1'b0);
    send_element(32'h8000_0000, 32'h8000_0000, 32'h8000_0000, 32'h8000_0000, 1'b0);
    send_element(32'h7FFF_FFFF, 32'h8000_0000, 32'h8000_0000, 32'h7FFF_FFFF, 1'b0);
    send_element(32'sd0, 32'sd0, 32'sd0, 32'sd0, 1'b1);
    send_element(32'sd1, -32'sd1, 32'h7FFF_FFFF, 32'h8000_0000, 1'b1);
    send_element(32'h0001_0000, -32'sd65536, 32'h0000_8000, 32'sd3, 1'b0);

    // Linear interpolation at 0, 1/3, 2/3, 1
    wait_drained();
    write_basis('{CoefOne, CoefZero, CoefTwoThirds, CoefThird,
                  CoefThird, CoefTwoThirds, CoefZero, CoefOne});
    send_element(32'h0001_0000, 32'h0002_0000, -32'sd65536, 32'h0003_0000, 1'b0);
    send_element(32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h8000_0000, 32'h8000_0000, 1'b0);
    send_element(32'h0000_0001, 32'h0000_0002, 32'h0000_0003, 32'h0000_0004, 1'b0);
    send_element(-32'sd100000, 32'sd250000, 32'h1234_5678, 32'hEDCB_A988, 1'b1);

    // Random part: slow receiver, then slow sender, then no idling at all
    run_random_phase(34, 67, 60, 1'b0);
    run_random_phase(34, 67, 60, 1'b0);
    run_random_phase(67, 34, 60, 1'b0);
    run_random_phase(67, 34, 60, 1'b0);
    run_random_phase(0, 0, 60, 1'b1);
    run_random_phase(0, 0, 60, 1'b0);

    wait_drained();
    repeat (16) @(negedge clk);

    $display("tb_tensor_interp_2x2_to_4x4: %0d elements over %0d basis settings, %0d rows",
             elements_sent, basis_sets, rows_checked);
    $display("tb_tensor_interp_2x2_to_4x4: %0d clamped values, %0d config transfers",
             clamps, cfg_writes);
    if (errors == 0) begin
      $display("tb_tensor_interp_2x2_to_4x4: done, clean");
    end else begin
      $display("tb_tensor_interp_2x2_to_4x4: done, errors");
    end
    $finish;
  end

endmodule
